### hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/adl_pkg.sv
// package for the adc ladder button decoder: codes, widths and reset values
`timescale 1ns / 1ps
package adl_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 7;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 10;
  localparam int LEVEL_BITS    = 10;
  localparam int LIMIT_BITS    = 7;

  localparam logic [LEVEL_BITS-1:0] THRESH_RST     = 10'd90;
  localparam logic [LEVEL_BITS-1:0] BOUND_PM_RST   = 10'd200;
  localparam logic [LEVEL_BITS-1:0] BOUND_MM_RST   = 10'd380;
  localparam logic [LEVEL_BITS-1:0] BOUND_MN_RST   = 10'd480;
  localparam logic [LIMIT_BITS-1:0] PRESS_LIM_RST  = 7'd10;
  localparam logic [LIMIT_BITS-1:0] HOLD_LIM_RST   = 7'd100;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CHANGE_THRESHOLD = 3'd0,
    REG_BOUND_PLUS_MENU  = 3'd1,
    REG_BOUND_MENU_MINUS = 3'd2,
    REG_BOUND_MINUS_NONE = 3'd3,
    REG_PRESS_LIMIT      = 3'd4,
    REG_HOLD_LIMIT       = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_PLUS  = 2'd1,
    KEY_MENU  = 2'd2,
    KEY_MINUS = 2'd3
  } button_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_HOLD  = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    EB_PLUS  = 2'd0,
    EB_MENU  = 2'd1,
    EB_MINUS = 2'd2
  } event_button_t;

endpackage

### hw/rtl/adc_ladder_button_decoder_unit.sv
// top level of the adc ladder button decoder
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Decodes one keypad ADC sample per transaction into the current button (none,
// plus, menu, minus) and a press or hold event. Each sample is captured in an
// input register, then one pass of compare and counter logic updates the
// decoder state and loads the result register, so one transaction is taken
// every cycle when the output is not stalled.
// The input register keeps accepting while a result waits on out_stall until
// both stages are full. Configuration writes (cfg_ready is always high) must
// only be done while no transaction is in flight.
module adc_ladder_button_decoder_unit #(
  parameter int SAMPLE_BITS = adl_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = adl_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_event_kind,
  output logic [1:0]                       out_event_button,
  output logic [1:0]                       out_current_button,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [adl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [adl_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int LB = adl_pkg::LEVEL_BITS;
  localparam int MB = adl_pkg::LIMIT_BITS;
  localparam int CMP_W = (SAMPLE_BITS > LB) ? SAMPLE_BITS : LB;
  localparam int CNT_W = (COUNT_BITS > MB) ? COUNT_BITS : MB;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  logic [LB-1:0] thresh_r, bound_pm_r, bound_mm_r, bound_mn_r;
  logic [MB-1:0] press_lim_r, hold_lim_r;

  // pipeline and decoder state
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r;
  logic [1:0]             out_kind_r, out_btn_r, out_cur_r;
  logic [1:0]             out_kind_nxt, out_btn_nxt;
  logic [SAMPLE_BITS-1:0] last_sample_r;
  adl_pkg::button_t       dec_r, dec_nxt;
  logic [COUNT_BITS-1:0]  plus_cnt_r, menu_cnt_r, minus_cnt_r;
  logic [COUNT_BITS-1:0]  plus_cnt_nxt, menu_cnt_nxt, minus_cnt_nxt;

  logic advance;
  logic [SAMPLE_BITS-1:0] diff;
  logic [CMP_W-1:0] s_ext, pm_ext, mm_ext, mn_ext;
  logic [1:0] ev_plus, ev_menu, ev_minus;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_event_button   = out_btn_r;
  assign out_current_button = out_cur_r;

  // one counter step: returns event kind, next count through cnt_n
  function automatic logic [1:0] track(input logic [COUNT_BITS-1:0] c, input logic held,
                                       input logic [MB-1:0] plim, input logic [MB-1:0] hlim,
                                       output logic [COUNT_BITS-1:0] cnt_n);
    logic [CNT_W-1:0] c_e, p_e, h_e;
    logic [1:0] ev;
    c_e = CNT_W'(c);
    p_e = CNT_W'(plim);
    h_e = CNT_W'(hlim);
    if (held) begin
      if (c_e < h_e && c != COUNT_MAX) begin
        cnt_n = c + 1'b1;
        ev = adl_pkg::EV_NONE;
      end else begin
        cnt_n = c;
        ev = adl_pkg::EV_HOLD;
      end
    end else begin
      cnt_n = '0;
      ev = (c_e >= p_e && c_e < h_e) ? adl_pkg::EV_PRESS : adl_pkg::EV_NONE;
    end
    return ev;
  endfunction

  assign diff = (s1_sample_r >= last_sample_r) ? (s1_sample_r - last_sample_r)
                                               : (last_sample_r - s1_sample_r);
  assign s_ext  = CMP_W'(s1_sample_r);
  assign pm_ext = CMP_W'(bound_pm_r);
  assign mm_ext = CMP_W'(bound_mm_r);
  assign mn_ext = CMP_W'(bound_mn_r);

  always_comb begin
    dec_nxt = dec_r;
    if (CMP_W'(diff) > CMP_W'(thresh_r)) begin
      if (dec_r != adl_pkg::KEY_PLUS && s_ext < pm_ext)
        dec_nxt = adl_pkg::KEY_PLUS;
      else if (dec_r != adl_pkg::KEY_MENU && s_ext > pm_ext && s_ext < mm_ext)
        dec_nxt = adl_pkg::KEY_MENU;
      else if (dec_r != adl_pkg::KEY_MINUS && s_ext > mm_ext && s_ext < mn_ext)
        dec_nxt = adl_pkg::KEY_MINUS;
      else if (dec_r != adl_pkg::KEY_NONE && s_ext > mn_ext)
        dec_nxt = adl_pkg::KEY_NONE;
    end
  end

  always_comb begin
    ev_plus  = track(plus_cnt_r, dec_nxt == adl_pkg::KEY_PLUS, press_lim_r, hold_lim_r,
                     plus_cnt_nxt);
    ev_minus = track(minus_cnt_r, dec_nxt == adl_pkg::KEY_MINUS, press_lim_r, hold_lim_r,
                     minus_cnt_nxt);
    ev_menu  = track(menu_cnt_r, dec_nxt == adl_pkg::KEY_MENU, press_lim_r, hold_lim_r,
                     menu_cnt_nxt);
    // plus wins over minus, minus over menu
    out_kind_nxt = adl_pkg::EV_NONE;
    out_btn_nxt  = adl_pkg::EB_PLUS;
    if (ev_plus != adl_pkg::EV_NONE) begin
      out_kind_nxt = ev_plus;
      out_btn_nxt  = adl_pkg::EB_PLUS;
    end else if (ev_minus != adl_pkg::EV_NONE) begin
      out_kind_nxt = ev_minus;
      out_btn_nxt  = adl_pkg::EB_MINUS;
    end else if (ev_menu != adl_pkg::EV_NONE) begin
      out_kind_nxt = ev_menu;
      out_btn_nxt  = adl_pkg::EB_MENU;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= adl_pkg::THRESH_RST;
      bound_pm_r  <= adl_pkg::BOUND_PM_RST;
      bound_mm_r  <= adl_pkg::BOUND_MM_RST;
      bound_mn_r  <= adl_pkg::BOUND_MN_RST;
      press_lim_r <= adl_pkg::PRESS_LIM_RST;
      hold_lim_r  <= adl_pkg::HOLD_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adl_pkg::REG_CHANGE_THRESHOLD: thresh_r    <= cfg_data[LB-1:0];
        adl_pkg::REG_BOUND_PLUS_MENU:  bound_pm_r  <= cfg_data[LB-1:0];
        adl_pkg::REG_BOUND_MENU_MINUS: bound_mm_r  <= cfg_data[LB-1:0];
        adl_pkg::REG_BOUND_MINUS_NONE: bound_mn_r  <= cfg_data[LB-1:0];
        adl_pkg::REG_PRESS_LIMIT:      press_lim_r <= cfg_data[MB-1:0];
        adl_pkg::REG_HOLD_LIMIT:       hold_lim_r  <= cfg_data[MB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_sample_r <= '0;
      dec_r         <= adl_pkg::KEY_NONE;
      plus_cnt_r    <= '0;
      menu_cnt_r    <= '0;
      minus_cnt_r   <= '0;
    end else begin
      if (in_valid && !in_stall)
        s1_valid_r <= 1'b1;
      else if (advance)
        s1_valid_r <= 1'b0;
      if (advance)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
      if (advance) begin
        last_sample_r <= s1_sample_r;
        dec_r         <= dec_nxt;
        plus_cnt_r    <= plus_cnt_nxt;
        menu_cnt_r    <= menu_cnt_nxt;
        minus_cnt_r   <= minus_cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      s1_sample_r <= in_sample;
    if (advance) begin
      out_kind_r <= out_kind_nxt;
      out_btn_r  <= out_btn_nxt;
      out_cur_r  <= dec_nxt;
    end
  end

  // only the decoded button may have a nonzero hold count
  `ASSERT_RST(a_one_count, clk, rst_n,
    $countones({plus_cnt_r != '0, menu_cnt_r != '0, minus_cnt_r != '0}) <= 1)
  `ASSERT_RST(a_stall_full, clk, rst_n, in_stall |-> (s1_valid_r && out_valid_r))
  `ASSERT_RST(a_hold_cur, clk, rst_n,
    (out_valid && out_event_kind == adl_pkg::EV_HOLD) |->
      ((out_event_button == adl_pkg::EB_PLUS && out_current_button == adl_pkg::KEY_PLUS) ||
       (out_event_button == adl_pkg::EB_MENU && out_current_button == adl_pkg::KEY_MENU) ||
       (out_event_button == adl_pkg::EB_MINUS && out_current_button == adl_pkg::KEY_MINUS)))
  `ASSERT_RST(a_press_rel, clk, rst_n,
    (out_valid && out_event_kind == adl_pkg::EV_PRESS) |->
      !((out_event_button == adl_pkg::EB_PLUS && out_current_button == adl_pkg::KEY_PLUS) ||
        (out_event_button == adl_pkg::EB_MENU && out_current_button == adl_pkg::KEY_MENU) ||
        (out_event_button == adl_pkg::EB_MINUS && out_current_button == adl_pkg::KEY_MINUS)))
  `ASSERT_RST(a_none_btn, clk, rst_n,
    (out_valid && out_event_kind == adl_pkg::EV_NONE) |-> out_event_button == adl_pkg::EB_PLUS)

endmodule
